// ----- design/hfs_pkg.sv -----
// shared constants and types of the height field shader
`timescale 1ns / 1ps
package hfs_pkg;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_LIGHT_DIRECTION   = 3'd0;
    localparam t_cfg_idx CFG_HALF_VECTOR       = 3'd1;
    localparam t_cfg_idx CFG_DIFFUSE_GAIN      = 3'd2;
    localparam t_cfg_idx CFG_SPECULAR_GAIN     = 3'd3;
    localparam t_cfg_idx CFG_AMBIENT_LEVEL     = 3'd4;
    localparam t_cfg_idx CFG_SPECULAR_EXPONENT = 3'd5;

    localparam int HEIGHT_W = 24;
    localparam int VEC_W    = 48;
    localparam int GAIN_W   = 16;
    localparam int EXP_W    = 8;
    localparam int OUT_W    = 16;

    localparam logic [47:0] RST_LIGHT_DIRECTION   = 48'd65322489875764;
    localparam logic [47:0] RST_HALF_VECTOR       = 48'd58815726360346;
    localparam logic [15:0] RST_DIFFUSE_GAIN      = 16'd16056;
    localparam logic [15:0] RST_SPECULAR_GAIN     = 16'd0;
    localparam logic [15:0] RST_AMBIENT_LEVEL     = 16'd328;
    localparam logic [7:0]  RST_SPECULAR_EXPONENT = 8'd80;

    localparam logic [14:0] ONE_Q14 = 15'd16384;

endpackage

// ----- design/hfs_in_if.sv -----
// request channel carrying the four neighbor heights
`timescale 1ns / 1ps
interface hfs_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] height_east;
    logic signed [23:0] height_west;
    logic signed [23:0] height_south;
    logic signed [23:0] height_north;

    modport source(output valid, height_east, height_west, height_south, height_north,
                   input ready);
    modport sink(input valid, height_east, height_west, height_south, height_north,
                 output ready);
endinterface

// ----- design/hfs_out_if.sv -----
// result channel carrying the shaded intensity
`timescale 1ns / 1ps
interface hfs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] intensity;

    modport source(output valid, intensity, input ready);
    modport sink(input valid, intensity, output ready);
endinterface

// ----- design/height_field_shader.sv -----
// height field shader: normal, lambert and blinn-phong terms in one pipeline
//
// i_in carries one request per grid point: the four neighbor heights, signed,
// with HEIGHT_FRAC_BITS fraction bits. o_out returns one intensity per request,
// unsigned Q4.12, in request order. i_cfg_we writes register i_cfg_idx from
// i_cfg_data (light direction, half vector, diffuse gain, specular gain,
// ambient level, specular exponent); write only while no request is in flight.
// Throughput is one request per cycle while the skid register is empty. A
// request passes 63 registers: three setup stages, 32 square root stages
// (one result bit per stage), a divider load stage and 15 quotient stages
// for the normal, two dot product stages, eight power stages (one exponent
// bit per stage), a gain multiply stage and the output register.
// When the receiver stalls, the output register holds its result and a skid
// register catches one more; the pipeline freezes only once the skid is full,
// and i_in.ready falls in the same cycle. Nothing is lost or repeated.
// Synchronous reset empties the pipeline and loads the register defaults.
`timescale 1ns / 1ps
module height_field_shader #(
    parameter int HEIGHT_FRAC_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    hfs_in_if.sink                  i_in,
    hfs_out_if.source               o_out,
    input  logic                    i_cfg_we,
    input  hfs_pkg::t_cfg_idx       i_cfg_idx,
    input  logic [47:0]             i_cfg_data
);

    localparam int NP = 62;
    localparam int SQ_N = 32;
    localparam int DV_N = 15;
    localparam int PW_N = 8;
    localparam logic [23:0] DZ = 24'(2 << HEIGHT_FRAC_BITS);
    localparam logic [63:0] DZ_SQ = 64'(DZ) * 64'(DZ);

    // configuration registers
    logic [47:0] r_light;
    logic [47:0] r_half;
    logic [15:0] r_dgain;
    logic [15:0] r_sgain;
    logic [15:0] r_amb;
    logic [7:0]  r_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light <= hfs_pkg::RST_LIGHT_DIRECTION;
            r_half  <= hfs_pkg::RST_HALF_VECTOR;
            r_dgain <= hfs_pkg::RST_DIFFUSE_GAIN;
            r_sgain <= hfs_pkg::RST_SPECULAR_GAIN;
            r_amb   <= hfs_pkg::RST_AMBIENT_LEVEL;
            r_exp   <= hfs_pkg::RST_SPECULAR_EXPONENT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hfs_pkg::CFG_LIGHT_DIRECTION:   r_light <= i_cfg_data;
                hfs_pkg::CFG_HALF_VECTOR:       r_half  <= i_cfg_data;
                hfs_pkg::CFG_DIFFUSE_GAIN:      r_dgain <= i_cfg_data[15:0];
                hfs_pkg::CFG_SPECULAR_GAIN:     r_sgain <= i_cfg_data[15:0];
                hfs_pkg::CFG_AMBIENT_LEVEL:     r_amb   <= i_cfg_data[15:0];
                hfs_pkg::CFG_SPECULAR_EXPONENT: r_exp   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic          adv;
    logic [NP-1:0] r_vld;
    logic          r_ov;
    logic          r_skv;
    logic [15:0]   r_od;
    logic [15:0]   r_sk;
    logic [15:0]   w_res;

    assign adv         = !r_skv;
    assign i_in.ready  = adv;
    assign o_out.valid = r_ov;
    assign o_out.intensity = r_od;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NP-2:0], i_in.valid};
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else begin
            if (r_skv) begin
                if (o_out.ready) begin
                    r_od  <= r_sk;
                    r_skv <= 1'b0;
                end
            end else if (r_vld[NP-1]) begin
                if (!r_ov || o_out.ready) begin
                    r_od <= w_res;
                    r_ov <= 1'b1;
                end else begin
                    r_sk  <= w_res;
                    r_skv <= 1'b1;
                end
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // differences
    logic signed [24:0] r_dx;
    logic signed [24:0] r_dy;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dx <= 25'(i_in.height_east) - 25'(i_in.height_west);
            r_dy <= 25'(i_in.height_south) - 25'(i_in.height_north);
        end
    end

    // magnitudes and squares
    logic [23:0] w_mx;
    logic [23:0] w_my;
    logic [23:0] r_mx;
    logic [23:0] r_my;
    logic        r_sgx;
    logic        r_sgy;
    logic [47:0] r_sqx;
    logic [47:0] r_sqy;

    assign w_mx = r_dx[24] ? 24'(-r_dx) : 24'(r_dx);
    assign w_my = r_dy[24] ? 24'(-r_dy) : 24'(r_dy);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mx  <= w_mx;
            r_my  <= w_my;
            r_sgx <= r_dx[24];
            r_sgy <= r_dy[24];
            r_sqx <= w_mx * w_mx;
            r_sqy <= w_my * w_my;
        end
    end

    // square root pipeline, entry 0 is the radicand stage
    logic [63:0] r_sx  [0:SQ_N];
    logic [63:0] r_sr  [0:SQ_N];
    logic [23:0] r_smx [0:SQ_N];
    logic [23:0] r_smy [0:SQ_N];
    logic        r_ssx [0:SQ_N];
    logic        r_ssy [0:SQ_N];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sx[0]  <= (64'(r_sqx) + 64'(r_sqy) + DZ_SQ) << 14;
            r_sr[0]  <= '0;
            r_smx[0] <= r_mx;
            r_smy[0] <= r_my;
            r_ssx[0] <= r_sgx;
            r_ssy[0] <= r_sgy;
        end
    end

    for (genvar i = 1; i <= SQ_N; i++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (64 - 2 * i);
        logic [63:0] w_t;
        assign w_t = r_sr[i-1] + BIT;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (r_sx[i-1] >= w_t) begin
                    r_sx[i] <= r_sx[i-1] - w_t;
                    r_sr[i] <= (r_sr[i-1] >> 1) + BIT;
                end else begin
                    r_sx[i] <= r_sx[i-1];
                    r_sr[i] <= r_sr[i-1] >> 1;
                end
                r_smx[i] <= r_smx[i-1];
                r_smy[i] <= r_smy[i-1];
                r_ssx[i] <= r_ssx[i-1];
                r_ssy[i] <= r_ssy[i-1];
            end
        end
    end

    // normal divider, three lanes, one quotient bit per stage
    logic [46:0] r_rem [0:DV_N][0:2];
    logic [14:0] r_q   [0:DV_N][0:2];
    logic [31:0] r_rt  [0:DV_N];
    logic        r_dsx [0:DV_N];
    logic        r_dsy [0:DV_N];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rem[0][0] <= 47'(r_smx[SQ_N]) << 21;
            r_rem[0][1] <= 47'(r_smy[SQ_N]) << 21;
            r_rem[0][2] <= 47'(DZ) << 21;
            for (int j = 0; j < 3; j++) begin
                r_q[0][j] <= '0;
            end
            r_rt[0]  <= r_sr[SQ_N][31:0];
            r_dsx[0] <= r_ssx[SQ_N];
            r_dsy[0] <= r_ssy[SQ_N];
        end
    end

    for (genvar k = 1; k <= DV_N; k++) begin : g_div
        logic [46:0] w_dv;
        assign w_dv = 47'(r_rt[k-1]) << (DV_N - k);
        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int j = 0; j < 3; j++) begin
                    if (r_rem[k-1][j] >= w_dv) begin
                        r_rem[k][j] <= r_rem[k-1][j] - w_dv;
                        r_q[k][j]   <= {r_q[k-1][j][13:0], 1'b1};
                    end else begin
                        r_rem[k][j] <= r_rem[k-1][j];
                        r_q[k][j]   <= {r_q[k-1][j][13:0], 1'b0};
                    end
                end
                r_rt[k]  <= r_rt[k-1];
                r_dsx[k] <= r_dsx[k-1];
                r_dsy[k] <= r_dsy[k-1];
            end
        end
    end

    // signed normal and dot products
    logic signed [15:0] w_n [0:2];
    logic signed [31:0] r_pl [0:2];
    logic signed [31:0] r_ph [0:2];

    assign w_n[0] = r_dsx[DV_N] ? -$signed({1'b0, r_q[DV_N][0]})
                                :  $signed({1'b0, r_q[DV_N][0]});
    assign w_n[1] = r_dsy[DV_N] ? -$signed({1'b0, r_q[DV_N][1]})
                                :  $signed({1'b0, r_q[DV_N][1]});
    assign w_n[2] = $signed({1'b0, r_q[DV_N][2]});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r_pl[j] <= w_n[j] * $signed(r_light[16*j +: 16]);
                r_ph[j] <= w_n[j] * $signed(r_half[16*j +: 16]);
            end
        end
    end

    function automatic logic [14:0] clamp_dot(input logic signed [33:0] s);
        logic [19:0] t;
        t = 20'(s >>> 14);
        if (s <= 0) begin
            return '0;
        end else if (t > 20'(hfs_pkg::ONE_Q14)) begin
            return hfs_pkg::ONE_Q14;
        end else begin
            return t[14:0];
        end
    endfunction

    logic signed [33:0] w_sl;
    logic signed [33:0] w_sh;
    logic [14:0]        r_dl  [0:PW_N];
    logic [14:0]        r_acc [0:PW_N];
    logic [14:0]        r_bas [0:PW_N];

    assign w_sl = 34'(r_pl[0]) + 34'(r_pl[1]) + 34'(r_pl[2]);
    assign w_sh = 34'(r_ph[0]) + 34'(r_ph[1]) + 34'(r_ph[2]);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dl[0]  <= clamp_dot(w_sl);
            r_bas[0] <= clamp_dot(w_sh);
            r_acc[0] <= hfs_pkg::ONE_Q14;
        end
    end

    // power by repeated squaring, one exponent bit per stage
    for (genvar b = 1; b <= PW_N; b++) begin : g_pow
        logic [29:0] w_pa;
        logic [29:0] w_pb;
        assign w_pa = r_acc[b-1] * r_bas[b-1];
        assign w_pb = r_bas[b-1] * r_bas[b-1];
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_acc[b] <= r_exp[b-1] ? w_pa[28:14] : r_acc[b-1];
                r_bas[b] <= w_pb[28:14];
                r_dl[b]  <= r_dl[b-1];
            end
        end
    end

    // gains and final sum
    logic [30:0] r_gd;
    logic [30:0] r_gs;
    logic [32:0] w_sum;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_gd <= r_dgain * r_dl[PW_N];
            r_gs <= r_sgain * r_acc[PW_N];
        end
    end

    assign w_sum = 33'({r_amb, 14'd0}) + 33'(r_gd) + 33'(r_gs);
    assign w_res = w_sum[32] ? 16'hFFFF : w_sum[31:16];

endmodule
